// ===== hdl/lzw_decompressor_variable_width_defines.svh =====
// Assertion macros shared by the LZW decoder RTL.
`ifndef LZW_DECOMPRESSOR_VARIABLE_WIDTH_DEFINES_SVH
`define LZW_DECOMPRESSOR_VARIABLE_WIDTH_DEFINES_SVH
`ifndef SYNTHESIS
// Invariant checked at every rising clock edge outside reset.
`define LZWD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define LZWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZWD_ASSERT(lbl, prop, msg)
`define LZWD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/lzwd_pkg.sv =====
// Package with constants, types and state encoding of the LZW decoder.
package lzwd_pkg;
    localparam int DICT_ENTRIES  = 8192;
    localparam int MAX_CODE_BITS = 13;
    localparam int ADDR_W        = $clog2(DICT_ENTRIES);
    localparam int LEVEL_W       = ADDR_W + 1;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int WIDTH_W       = $clog2(MAX_CODE_BITS + 1);

    localparam logic [CODE_W-1:0]  CODE_END        = CODE_W'(12'h100);
    localparam logic [CODE_W-1:0]  CODE_WIDEN      = CODE_W'(12'h101);
    localparam logic [CODE_W-1:0]  CODE_CLEAR      = CODE_W'(12'h102);
    localparam logic [LEVEL_W-1:0] CODE_FIRST_FREE = LEVEL_W'(12'h103);
    localparam logic [CODE_W-1:0]  LITERAL_MAX     = CODE_W'(8'hFF);
    localparam logic [WIDTH_W-1:0] START_WIDTH     = WIDTH_W'(9);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH       = WIDTH_W'(MAX_CODE_BITS);
    localparam logic [LEVEL_W-1:0] STACK_DEPTH     = LEVEL_W'(DICT_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DECODE,
        ST_WALK_CHK,
        ST_WALK_USE,
        ST_FINISH,
        ST_PULL_RD,
        ST_RESP
    } t_state;

    // Write and read request towards the dictionary.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CODE_W-1:0] wprefix;
        logic [7:0]        wsuffix;
        logic [ADDR_W-1:0] raddr;
    } t_dict_req;
endpackage

// ===== hdl/lzwd_in_if.sv =====
// Input channel: one request beat (push a byte or pull a byte).
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

// ===== hdl/lzwd_out_if.sv =====
// Output channel: one result beat per request.
interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       more_pending;
    logic       need_byte;
    logic       finished;

    modport source (output valid, output out_byte, output out_valid, output more_pending,
                    output need_byte, output finished, input ready);
    modport sink (input valid, input out_byte, input out_valid, input more_pending,
                  input need_byte, input finished, output ready);
endinterface

// ===== hdl/lzwd_dict.sv =====
// Dictionary storage: prefix and suffix memories with registered read.
module lzwd_dict (
    input  logic                          i_clk,
    input  lzwd_pkg::t_dict_req           i_req,
    output logic [lzwd_pkg::CODE_W-1:0]   o_prefix,
    output logic [7:0]                    o_suffix
);
    logic [lzwd_pkg::CODE_W-1:0] r_prefix_mem [lzwd_pkg::DICT_ENTRIES];
    logic [7:0]                  r_suffix_mem [lzwd_pkg::DICT_ENTRIES];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_prefix_mem[i_req.waddr] <= i_req.wprefix;
            r_suffix_mem[i_req.waddr] <= i_req.wsuffix;
        end
        o_prefix <= r_prefix_mem[i_req.raddr];
        o_suffix <= r_suffix_mem[i_req.raddr];
    end
endmodule

// ===== hdl/lzw_decompressor_variable_width.sv =====
// LZW decoder top level: bit unpacker, code sequencer, dictionary walk and string stack.
// A pull goes through ST_PULL_RD (if the stack is not empty) and ST_RESP to raise its result beat.
// A push shifts in its input bits one by one (8, fewer once the end code is seen), decodes each
// code, walks each character through the dictionary (paced by its registered read) and answers
// in ST_RESP. One request is in flight at a time; the next beat is taken the cycle after the
// result leaves. Reset is synchronous and active low; memories need no clear.
module lzw_decompressor_variable_width (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzwd_in_if.sink     i_in,
    lzwd_out_if.source  o_out
);
    localparam int CW = lzwd_pkg::CODE_W;
    localparam int AW = lzwd_pkg::ADDR_W;
    localparam int LW = lzwd_pkg::LEVEL_W;
    localparam int WW = lzwd_pkg::WIDTH_W;

    lzwd_pkg::t_state r_state, n_state;

    logic [7:0]    r_byte, n_byte;
    logic [3:0]    r_rem, n_rem;
    logic [CW-1:0] r_accum, n_accum;
    logic [WW-1:0] r_held, n_held;
    logic [WW-1:0] r_width, n_width;
    logic [LW-1:0] r_next_free, n_next_free;
    logic [CW-1:0] r_prev, n_prev;
    logic          r_first, n_first;
    logic          r_end, n_end;
    logic [LW-1:0] r_level, n_level;
    logic [CW-1:0] r_code, n_code;
    logic [CW-1:0] r_walk, n_walk;
    logic          r_special, n_special;
    logic [7:0]    r_fchar, n_fchar;
    logic          r_pull_ok, n_pull_ok;

    logic          r_out_full;
    logic [7:0]    r_out_byte;
    logic          r_out_vld;
    logic          r_out_more;
    logic          r_out_need;
    logic          r_out_fin;

    logic [7:0]    r_stack_mem [lzwd_pkg::DICT_ENTRIES];
    logic [7:0]    r_stack_q;
    logic          w_stk_we;
    logic [AW-1:0] w_stk_addr;
    logic [7:0]    w_stk_data;

    lzwd_pkg::t_dict_req w_dict_req;
    logic [CW-1:0]       w_dict_prefix;
    logic [7:0]          w_dict_suffix;

    logic          w_accept;
    logic [CW-1:0] w_acc_sh;
    logic [WW-1:0] w_held_inc;
    logic          w_code_done;
    logic          w_room;
    logic          w_is_special;
    lzwd_pkg::t_state w_cont_state;

    lzwd_dict u_dict (
        .i_clk    (i_clk),
        .i_req    (w_dict_req),
        .o_prefix (w_dict_prefix),
        .o_suffix (w_dict_suffix)
    );

    // Handshake and shared shift unit.
    assign i_in.ready   = (r_state == lzwd_pkg::ST_IDLE) && !r_out_full;
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_acc_sh     = {r_accum[CW-2:0], r_byte[7]};
    assign w_held_inc   = r_held + WW'(1);
    assign w_code_done  = (w_held_inc >= r_width);
    assign w_room       = (r_next_free < lzwd_pkg::STACK_DEPTH);
    assign w_is_special = (LW'(r_code) >= r_next_free);
    assign w_cont_state = (r_rem == 4'd0) ? lzwd_pkg::ST_RESP : lzwd_pkg::ST_SHIFT;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzwd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.req_type) begin
                        n_state = (r_level != '0) ? lzwd_pkg::ST_PULL_RD : lzwd_pkg::ST_RESP;
                    end else begin
                        n_state = (!r_end && r_level == '0) ? lzwd_pkg::ST_SHIFT
                                                            : lzwd_pkg::ST_RESP;
                    end
                end
            end
            lzwd_pkg::ST_SHIFT: begin
                if (w_code_done) begin
                    n_state = lzwd_pkg::ST_DECODE;
                end else if (r_rem == 4'd1) begin
                    n_state = lzwd_pkg::ST_RESP;
                end
            end
            lzwd_pkg::ST_DECODE: begin
                if (r_code == lzwd_pkg::CODE_END) begin
                    n_state = lzwd_pkg::ST_RESP;
                end else if (r_code == lzwd_pkg::CODE_CLEAR || r_code == lzwd_pkg::CODE_WIDEN
                             || r_first) begin
                    n_state = w_cont_state;
                end else begin
                    n_state = lzwd_pkg::ST_WALK_CHK;
                end
            end
            lzwd_pkg::ST_WALK_CHK: begin
                n_state = (r_walk > lzwd_pkg::LITERAL_MAX) ? lzwd_pkg::ST_WALK_USE
                                                          : lzwd_pkg::ST_FINISH;
            end
            lzwd_pkg::ST_WALK_USE: n_state = lzwd_pkg::ST_WALK_CHK;
            lzwd_pkg::ST_FINISH:   n_state = w_cont_state;
            lzwd_pkg::ST_PULL_RD:  n_state = lzwd_pkg::ST_RESP;
            lzwd_pkg::ST_RESP:     n_state = lzwd_pkg::ST_IDLE;
            default:               n_state = lzwd_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and next register values.
    always_comb begin
        n_byte      = r_byte;
        n_rem       = r_rem;
        n_accum     = r_accum;
        n_held      = r_held;
        n_width     = r_width;
        n_next_free = r_next_free;
        n_prev      = r_prev;
        n_first     = r_first;
        n_end       = r_end;
        n_level     = r_level;
        n_code      = r_code;
        n_walk      = r_walk;
        n_special   = r_special;
        n_fchar     = r_fchar;
        n_pull_ok   = r_pull_ok;
        w_stk_we    = 1'b0;
        w_stk_addr  = r_level[AW-1:0];
        w_stk_data  = 8'h00;
        w_dict_req.we      = 1'b0;
        w_dict_req.waddr   = r_next_free[AW-1:0];
        w_dict_req.wprefix = r_prev;
        w_dict_req.wsuffix = r_fchar;
        w_dict_req.raddr   = r_walk[AW-1:0];
        unique case (r_state)
            lzwd_pkg::ST_IDLE: begin
                n_pull_ok = 1'b0;
                if (w_accept) begin
                    n_byte = i_in.in_byte;
                    n_rem  = 4'd8;
                    if (i_in.req_type && r_level != '0) begin
                        n_level   = r_level - LW'(1);
                        n_pull_ok = 1'b1;
                    end
                end
            end
            lzwd_pkg::ST_SHIFT: begin
                n_byte = {r_byte[6:0], 1'b0};
                n_rem  = r_rem - 4'd1;
                if (w_code_done) begin
                    n_code  = w_acc_sh;
                    n_accum = '0;
                    n_held  = '0;
                end else begin
                    n_accum = w_acc_sh;
                    n_held  = w_held_inc;
                end
            end
            lzwd_pkg::ST_DECODE: begin
                if (r_code == lzwd_pkg::CODE_END) begin
                    n_end   = 1'b1;
                    n_accum = '0;
                    n_held  = '0;
                end else if (r_code == lzwd_pkg::CODE_CLEAR) begin
                    n_next_free = lzwd_pkg::CODE_FIRST_FREE;
                    n_width     = lzwd_pkg::START_WIDTH;
                    n_first     = 1'b1;
                end else if (r_code == lzwd_pkg::CODE_WIDEN) begin
                    if (r_width < lzwd_pkg::MAX_WIDTH) begin
                        n_width = r_width + WW'(1);
                    end
                end else if (r_first) begin
                    // First code after a clear is taken as a literal.
                    n_prev  = CW'(r_code[7:0]);
                    n_first = 1'b0;
                    if (r_level < lzwd_pkg::STACK_DEPTH) begin
                        w_stk_we   = 1'b1;
                        w_stk_data = r_code[7:0];
                        n_level    = r_level + LW'(1);
                    end
                end else begin
                    // Known code: walk it. Unknown code: hold a slot for its first character, walk the previous.
                    n_special = w_is_special;
                    n_walk    = w_is_special ? r_prev : r_code;
                    if (w_is_special && r_level < lzwd_pkg::STACK_DEPTH) begin
                        w_stk_we   = 1'b1;
                        w_stk_data = 8'h00;
                        n_level    = r_level + LW'(1);
                    end
                end
            end
            lzwd_pkg::ST_WALK_CHK: begin
                if (r_walk <= lzwd_pkg::LITERAL_MAX) begin
                    n_fchar = r_walk[7:0];
                    if (r_level < lzwd_pkg::STACK_DEPTH) begin
                        w_stk_we   = 1'b1;
                        w_stk_data = r_walk[7:0];
                        n_level    = r_level + LW'(1);
                    end
                end
            end
            lzwd_pkg::ST_WALK_USE: begin
                n_walk = w_dict_prefix;
                if (r_level < lzwd_pkg::STACK_DEPTH) begin
                    w_stk_we   = 1'b1;
                    w_stk_data = w_dict_suffix;
                    n_level    = r_level + LW'(1);
                end
            end
            lzwd_pkg::ST_FINISH: begin
                if (r_special) begin
                    w_stk_we   = 1'b1;
                    w_stk_addr = '0;
                    w_stk_data = r_fchar;
                end
                if (w_room) begin
                    w_dict_req.we = 1'b1;
                    n_next_free   = r_next_free + LW'(1);
                end
                if (!r_special) begin
                    n_prev = r_code;
                end else if (w_room) begin
                    n_prev = r_next_free[CW-1:0];
                end
            end
            lzwd_pkg::ST_PULL_RD: begin
                n_pull_ok = r_pull_ok;
            end
            lzwd_pkg::ST_RESP: begin
                n_pull_ok = r_pull_ok;
            end
            default: begin
                n_pull_ok = 1'b0;
            end
        endcase
    end

    // Sequencer and decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzwd_pkg::ST_IDLE;
            r_accum     <= '0;
            r_held      <= '0;
            r_width     <= lzwd_pkg::START_WIDTH;
            r_next_free <= lzwd_pkg::CODE_FIRST_FREE;
            r_prev      <= '0;
            r_first     <= 1'b1;
            r_end       <= 1'b0;
            r_level     <= '0;
            r_rem       <= '0;
            r_special   <= 1'b0;
            r_pull_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_accum     <= n_accum;
            r_held      <= n_held;
            r_width     <= n_width;
            r_next_free <= n_next_free;
            r_prev      <= n_prev;
            r_first     <= n_first;
            r_end       <= n_end;
            r_level     <= n_level;
            r_rem       <= n_rem;
            r_special   <= n_special;
            r_pull_ok   <= n_pull_ok;
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_code  <= n_code;
        r_walk  <= n_walk;
        r_fchar <= n_fchar;
    end

    // String stack memory with registered read at the current level.
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack_mem[w_stk_addr] <= w_stk_data;
        end
        r_stack_q <= r_stack_mem[r_level[AW-1:0]];
    end

    // Output register: holds one result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (r_state == lzwd_pkg::ST_RESP) begin
            r_out_full <= 1'b1;
        end else if (o_out.ready) begin
            r_out_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lzwd_pkg::ST_RESP) begin
            r_out_byte <= r_pull_ok ? r_stack_q : 8'h00;
            r_out_vld  <= r_pull_ok;
            r_out_more <= (r_level != '0);
            r_out_need <= !r_end && (r_level == '0);
            r_out_fin  <= r_end;
        end
    end

    assign o_out.valid        = r_out_full;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.out_valid    = r_out_vld;
    assign o_out.more_pending = r_out_more;
    assign o_out.need_byte    = r_out_need;
    assign o_out.finished     = r_out_fin;

`include "lzw_decompressor_variable_width_defines.svh"

    `LZWD_ASSERT(a_held_below_width, r_held < r_width, "bit count reached code width")
    `LZWD_ASSERT(a_width_range, r_width >= lzwd_pkg::START_WIDTH && r_width <= lzwd_pkg::MAX_WIDTH, "code width out of range")
    `LZWD_ASSERT(a_next_free_bound, r_next_free <= lzwd_pkg::STACK_DEPTH, "next free code beyond dictionary")
    `LZWD_ASSERT(a_level_bound, r_level <= lzwd_pkg::STACK_DEPTH, "stack level beyond depth")
    `LZWD_ASSERT_NEXT(a_busy_after_accept, w_accept, !i_in.ready, "ready while a request is in work")
endmodule

// ===== test/lzw_decompressor_variable_width_tb.sv =====
// Self-checking testbench for the LZW decoder: code streams in, decoded bytes checked.

// Decoder state tracker and store of expected response beats.
class lzw_scoreboard;
    typedef struct {
        bit [7:0] byte_out;
        bit       byte_ok;
        bit       more;
        bit       need;
        bit       done;
    } t_resp;

    bit [12:0] chain_prefix [lzwd_pkg::DICT_ENTRIES];
    bit [7:0]  chain_suffix [lzwd_pkg::DICT_ENTRIES];
    bit [7:0]  char_stack   [lzwd_pkg::DICT_ENTRIES];
    int unsigned stack_fill;
    int unsigned shift_reg;
    int unsigned shift_count;
    int unsigned width;
    int unsigned free_code;
    int unsigned last_code;
    bit          awaiting_first;
    bit          ended;

    t_resp expected_resp[$];
    int    errors;
    int    beats_checked;
    int    strings_decoded;

    function new();
        stack_fill     = 0;
        shift_reg      = 0;
        shift_count    = 0;
        last_code      = 0;
        ended          = 0;
        errors         = 0;
        beats_checked  = 0;
        strings_decoded = 0;
        wipe_dictionary();
    endfunction

    function void wipe_dictionary();
        free_code      = lzwd_pkg::CODE_FIRST_FREE;
        width          = lzwd_pkg::START_WIDTH;
        awaiting_first = 1;
    endfunction

    function void stack_char(bit [7:0] c);
        if (stack_fill < lzwd_pkg::DICT_ENTRIES) begin
            char_stack[stack_fill] = c;
            stack_fill++;
        end
    endfunction

    // Walks a chain from its last character back to the root; returns the root.
    function bit [7:0] stack_string(int unsigned c);
        int unsigned steps;
        int unsigned idx;
        steps = 0;
        while (c > 255 && steps < lzwd_pkg::DICT_ENTRIES) begin
            idx = c % lzwd_pkg::DICT_ENTRIES;
            stack_char(chain_suffix[idx]);
            c = chain_prefix[idx];
            steps++;
        end
        stack_char(c[7:0]);
        return c[7:0];
    endfunction

    function void apply_code(int unsigned code);
        bit          kwk;
        bit          room;
        bit [7:0]    head;
        int unsigned made;
        if (code == lzwd_pkg::CODE_END) begin
            ended = 1;
            return;
        end
        if (code == lzwd_pkg::CODE_CLEAR) begin
            wipe_dictionary();
            return;
        end
        if (code == lzwd_pkg::CODE_WIDEN) begin
            if (width < lzwd_pkg::MAX_CODE_BITS) width++;
            return;
        end
        strings_decoded++;
        if (awaiting_first) begin
            stack_char(code[7:0]);
            last_code      = code & 8'hFF;
            awaiting_first = 0;
            return;
        end
        kwk  = code >= free_code;
        room = free_code < lzwd_pkg::DICT_ENTRIES;
        made = free_code;
        if (kwk) begin
            // The repeated-prefix case: previous string followed by its own head.
            stack_char(8'h00);
            head = stack_string(last_code);
            char_stack[0] = head;
        end else begin
            head = stack_string(code);
        end
        if (room) begin
            chain_prefix[made] = last_code;
            chain_suffix[made] = head;
            free_code++;
        end
        if (!kwk) last_code = code;
        else if (room) last_code = made;
    endfunction

    // Records an accepted request beat and works out its response.
    function void note_request(bit pull, bit [7:0] data);
        t_resp r;
        r.byte_out = 8'h00;
        r.byte_ok  = 0;
        if (pull) begin
            if (stack_fill > 0) begin
                stack_fill--;
                r.byte_out = char_stack[stack_fill];
                r.byte_ok  = 1;
            end
        end else if (!ended && stack_fill == 0) begin
            for (int b = 7; b >= 0 && !ended; b--) begin
                shift_reg = ((shift_reg << 1) | data[b]) & 16'hFFFF;
                shift_count++;
                if (shift_count >= width) begin
                    int unsigned code;
                    code        = shift_reg;
                    shift_reg   = 0;
                    shift_count = 0;
                    apply_code(code);
                end
            end
            if (ended) begin
                shift_reg   = 0;
                shift_count = 0;
            end
        end
        r.more = stack_fill > 0;
        r.need = !ended && stack_fill == 0;
        r.done = ended;
        expected_resp.push_back(r);
    endfunction

    function void check_result(bit [7:0] byte_out, bit byte_ok, bit more, bit need, bit done);
        t_resp e;
        if (expected_resp.size() == 0) begin
            $display("%0t: response beat with nothing expected (byte %02h)", $time, byte_out);
            errors++;
            return;
        end
        e = expected_resp.pop_front();
        beats_checked++;
        if (e.byte_out != byte_out || e.byte_ok != byte_ok || e.more != more ||
            e.need != need || e.done != done) begin
            $display("%0t: mismatch expected byte=%02h ok=%0b more=%0b need=%0b done=%0b",
                     $time, e.byte_out, e.byte_ok, e.more, e.need, e.done);
            $display("%0t:          actual   byte=%02h ok=%0b more=%0b need=%0b done=%0b",
                     $time, byte_out, byte_ok, more, need, done);
            errors++;
        end
    endfunction
endclass

module lzw_decompressor_variable_width_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 100000;

    logic i_clk;
    logic i_rst_n;

    lzwd_in_if  req_ch ();
    lzwd_out_if resp_ch ();

    lzw_decompressor_variable_width uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (resp_ch.source)
    );

    lzw_scoreboard sb;

    // Encoder-side view of the stream, kept in step with the codes emitted.
    bit          code_bits[$];
    int unsigned enc_width;
    int unsigned enc_free;
    bit          enc_first;
    bit          no_idle;
    int          beats_sent;
    int          idle_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = 1'b0;
        req_ch.in_byte   = 8'h00;
        resp_ch.ready    = 1'b0;
    end

    // Gap length: mostly short, now and then long, none in a no-idle stretch.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Response side stalls at random.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                resp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            resp_ch.ready <= 1'b1;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    end

    // Checks every accepted response beat.
    always @(posedge i_clk) begin
        if (i_rst_n && resp_ch.valid && resp_ch.ready) begin
            sb.check_result(resp_ch.out_byte, resp_ch.out_valid, resp_ch.more_pending,
                            resp_ch.need_byte, resp_ch.finished);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("[lzw_decompressor_variable_width] ERROR");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Sends one request beat; valid stays high across back-to-back beats.
    task automatic send_beat(bit pull, bit [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= pull;
        req_ch.in_byte  <= data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(pull, data);
        beats_sent++;
        if (beats_sent % 60 == 0) no_idle = ($urandom_range(3) == 0);
    endtask

    // Appends one code at the encoder's width and tracks its effect on the dictionary.
    function automatic void emit_code(int unsigned code);
        for (int b = enc_width - 1; b >= 0; b--) code_bits.push_back(code[b]);
        if (code == lzwd_pkg::CODE_CLEAR) begin
            enc_width = lzwd_pkg::START_WIDTH;
            enc_free  = lzwd_pkg::CODE_FIRST_FREE;
            enc_first = 1;
        end else if (code == lzwd_pkg::CODE_WIDEN) begin
            if (enc_width < lzwd_pkg::MAX_CODE_BITS) enc_width++;
        end else if (code != lzwd_pkg::CODE_END) begin
            if (enc_first) enc_first = 0;
            else if (enc_free < lzwd_pkg::DICT_ENTRIES) enc_free++;
        end
    endfunction

    // Picks a well-formed code; the fill flavour favours literals to grow the dictionary.
    function automatic void emit_random_code(bit fill);
        int unsigned top;
        int r;
        top = (1 << enc_width) - 1;
        r   = $urandom_range(99);
        if (enc_first) begin
            if (r < 8 && !fill) emit_code(lzwd_pkg::CODE_WIDEN);
            else if (r < 12 && !fill) emit_code(lzwd_pkg::CODE_CLEAR);
            else if (r < 30) emit_code($urandom_range(top, lzwd_pkg::CODE_FIRST_FREE));
            else emit_code($urandom_range(255));
        end else if (!fill && r < 3) begin
            emit_code(lzwd_pkg::CODE_WIDEN);
        end else if (!fill && r < 5) begin
            emit_code(lzwd_pkg::CODE_CLEAR);
        end else if (r < (fill ? 85 : 45) || enc_free == lzwd_pkg::CODE_FIRST_FREE) begin
            emit_code($urandom_range(255));
        end else if (r < (fill ? 95 : 88) || enc_free > top) begin
            emit_code($urandom_range(enc_free - 1, lzwd_pkg::CODE_FIRST_FREE));
        end else begin
            emit_code($urandom_range(top, enc_free));
        end
    endfunction

    // Pushes the queued stream and drains decoded strings, with some noise beats.
    task automatic run_stream(int beats, bit fill, bit refill);
        bit [7:0] b;
        int       stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at && (refill || code_bits.size() >= 8)) begin
            if (refill) begin
                while (code_bits.size() < 8) emit_random_code(fill);
                if (fill && enc_free >= lzwd_pkg::DICT_ENTRIES) refill = 0;
            end
            if (sb.stack_fill > 0) begin
                if ($urandom_range(19) == 0) send_beat(1'b0, 8'($urandom));
                else send_beat(1'b1, 8'h00);
            end else if ($urandom_range(24) == 0) begin
                send_beat(1'b1, 8'h00);
            end else begin
                for (int k = 0; k < 8; k++) b[7 - k] = code_bits.pop_front();
                send_beat(1'b0, b);
            end
        end
    endtask

    // Drops the request valid and waits until every expected response has arrived.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.expected_resp.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb         = new();
        beats_sent = 0;
        idle_count = 0;
        no_idle    = 0;
        enc_width  = lzwd_pkg::START_WIDTH;
        enc_free   = lzwd_pkg::CODE_FIRST_FREE;
        enc_first  = 1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first code above the literals, both literal extremes, the
        // repeated-prefix case at and above the free code, widening and clearing.
        send_beat(1'b1, 8'h00);
        emit_code(12'h1FF);
        emit_code(12'h000);
        emit_code(12'h0FF);
        emit_code(lzwd_pkg::CODE_FIRST_FREE);
        emit_code(enc_free);
        emit_code(12'h1F0);
        emit_code(lzwd_pkg::CODE_WIDEN);
        emit_code(12'h3FF);
        emit_code(lzwd_pkg::CODE_CLEAR);
        emit_code(lzwd_pkg::CODE_WIDEN);
        emit_code(12'h080);
        emit_code(12'h07F);
        emit_code(lzwd_pkg::CODE_FIRST_FREE);
        emit_code(lzwd_pkg::CODE_CLEAR);
        while (code_bits.size() % 8 != 0) emit_random_code(0);
        run_stream(25, 0, 0);

        // Random well-formed streams.
        run_stream(480, 0, 1);

        // Hold off until every response is in, then grow the dictionary at full width.
        wait_drained();
        for (int k = 0; k < 5; k++) emit_code(lzwd_pkg::CODE_WIDEN);
        run_stream(130, 1, 1);

        // Back to short codes, then the end code with bytes and pulls after it.
        emit_code(lzwd_pkg::CODE_CLEAR);
        run_stream(80, 0, 1);
        emit_code(lzwd_pkg::CODE_END);
        while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom));
        run_stream(100000, 0, 0);
        while (sb.stack_fill > 0) send_beat(1'b1, 8'h00);
        send_beat(1'b0, 8'($urandom));
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, 8'hFF);

        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("Run covered %0d request beats, %0d strings decoded, %0d responses checked,",
                 beats_sent, sb.strings_decoded, sb.beats_checked);
        $display("including widening, clearing, repeated-prefix codes and 13-bit codes.");
        if (sb.errors == 0 && sb.expected_resp.size() == 0) begin
            $display("[lzw_decompressor_variable_width] OK");
        end else begin
            $display("[lzw_decompressor_variable_width] ERROR");
        end
        $finish;
    end
endmodule
